// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file of the tilt-angle block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ACT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ACT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/acctilt_pkg.sv =====
// Types and constants shared by the tilt-angle CORDIC lanes.
`timescale 1ns / 1ps

package acctilt_pkg;

   localparam int AXIS_W     = 16;   // raw axis count
   localparam int OUT_W      = 16;   // angle, 1/128 degree
   localparam int FIX_SHIFT  = 24;
   localparam int OUT_SHIFT  = 17;
   localparam int OPND_W     = 43;   // |x|,|y| stay below 2^41 after CORDIC gain
   localparam int ANG_W      = 34;   // accumulator, 2^-24 degree
   localparam int ROUND_W    = ANG_W - OUT_SHIFT;
   localparam int TABLE_SIZE = 24;

   localparam logic signed [ANG_W-1:0]   QUARTER_TURN = 34'sd1509949440;
   localparam logic signed [ROUND_W-1:0] HALF_TURN    = 17'sd23040;

   // atan(2^-i) in degrees, times 2^24
   localparam logic signed [ANG_W-1:0] ATAN_TABLE [TABLE_SIZE] = '{
      34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
      34'sd60000934,  34'sd30029717,  34'sd15018523,  34'sd7509720,
      34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
      34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
      34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
      34'sd917,       34'sd458,       34'sd229,       34'sd115
   };

   typedef struct packed {
      logic [OPND_W-1:0] x;
      logic [OPND_W-1:0] y;
      logic [ANG_W-1:0]  z;
      logic              special;   // zero numerator, result fixed
      logic              half;      // fixed result is +180 degrees
   } cordic_type;

endpackage

// ===== hdl/acctilt_stage.sv =====
// One registered micro-rotation of the vectoring CORDIC.
`timescale 1ns / 1ps

module acctilt_stage #(
   parameter int STAGE_IDX = 0
) (
   input  logic                   clock,
   input  logic                   enable,
   input  acctilt_pkg::cordic_type src,
   output acctilt_pkg::cordic_type dst
);

   acctilt_pkg::cordic_type rot_in;
   acctilt_pkg::cordic_type rot_ff;

   logic signed [acctilt_pkg::OPND_W-1:0] x_s;
   logic signed [acctilt_pkg::OPND_W-1:0] y_s;
   logic signed [acctilt_pkg::OPND_W-1:0] xs;
   logic signed [acctilt_pkg::OPND_W-1:0] ys;
   logic signed [acctilt_pkg::ANG_W-1:0]  z_s;

   always_comb begin
      x_s = src.x;
      y_s = src.y;
      z_s = src.z;
      xs  = x_s >>> STAGE_IDX;
      ys  = y_s >>> STAGE_IDX;
      rot_in = src;
      // turn towards the x axis
      if (!y_s[acctilt_pkg::OPND_W-1]) begin
         rot_in.x = x_s + ys;
         rot_in.y = y_s - xs;
         rot_in.z = z_s + acctilt_pkg::ATAN_TABLE[STAGE_IDX];
      end else begin
         rot_in.x = x_s - ys;
         rot_in.y = y_s + xs;
         rot_in.z = z_s - acctilt_pkg::ATAN_TABLE[STAGE_IDX];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rot_ff <= rot_in;
      end
   end

   assign dst = rot_ff;

endmodule

// ===== hdl/acctilt_lane.sv =====
// One atan2 lane: quadrant fold, CORDIC stage chain and rounding.
`timescale 1ns / 1ps

module acctilt_lane #(
   parameter int NUM_STAGES = 16
) (
   input  logic                                 clock,
   input  logic                                 enable,
   input  logic signed [acctilt_pkg::AXIS_W-1:0] num,
   input  logic signed [acctilt_pkg::AXIS_W-1:0] den,
   output logic signed [acctilt_pkg::OUT_W-1:0]  angle
);

   localparam int EXT_W = acctilt_pkg::AXIS_W + 1;

   acctilt_pkg::cordic_type prep_in;
   acctilt_pkg::cordic_type prep_ff;
   acctilt_pkg::cordic_type chain [NUM_STAGES+1];

   logic signed [EXT_W-1:0] num_e;
   logic signed [EXT_W-1:0] den_e;
   logic signed [EXT_W-1:0] x0;
   logic signed [EXT_W-1:0] y0;
   logic signed [acctilt_pkg::OPND_W-1:0]  x_w;
   logic signed [acctilt_pkg::OPND_W-1:0]  y_w;
   logic signed [acctilt_pkg::ANG_W-1:0]   z_last;
   logic signed [acctilt_pkg::ANG_W-1:0]   z_round;
   logic signed [acctilt_pkg::ROUND_W-1:0] r;
   logic signed [acctilt_pkg::ROUND_W-1:0] r_clamp;

   // fold the vector into the right half-plane
   always_comb begin
      num_e = EXT_W'(num);
      den_e = EXT_W'(den);
      prep_in.special = (num == '0);
      prep_in.half    = den[acctilt_pkg::AXIS_W-1];
      if (den[acctilt_pkg::AXIS_W-1]) begin
         if (!num[acctilt_pkg::AXIS_W-1]) begin
            x0 = num_e;
            y0 = -den_e;
            prep_in.z = acctilt_pkg::QUARTER_TURN;
         end else begin
            x0 = -num_e;
            y0 = den_e;
            prep_in.z = -acctilt_pkg::QUARTER_TURN;
         end
      end else begin
         x0 = den_e;
         y0 = num_e;
         prep_in.z = '0;
      end
      x_w = acctilt_pkg::OPND_W'(x0) <<< acctilt_pkg::FIX_SHIFT;
      y_w = acctilt_pkg::OPND_W'(y0) <<< acctilt_pkg::FIX_SHIFT;
      prep_in.x = x_w;
      prep_in.y = y_w;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prep_ff <= prep_in;
      end
   end

   assign chain[0] = prep_ff;

   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
      acctilt_stage #(
         .STAGE_IDX (i)
      ) u_stage (
         .clock  (clock),
         .enable (enable),
         .src    (chain[i]),
         .dst    (chain[i+1])
      );
   end

   // round half up to 1/128 degree, then clamp to a half turn; a zero numerator gives 0 or +180 degrees
   always_comb begin
      z_last  = chain[NUM_STAGES].z;
      z_round = z_last + (acctilt_pkg::ANG_W'(1) <<< (acctilt_pkg::OUT_SHIFT - 1));
      r       = z_round[acctilt_pkg::ANG_W-1:acctilt_pkg::OUT_SHIFT];
      if (r > acctilt_pkg::HALF_TURN) begin
         r_clamp = acctilt_pkg::HALF_TURN;
      end else if (r < -acctilt_pkg::HALF_TURN) begin
         r_clamp = -acctilt_pkg::HALF_TURN;
      end else begin
         r_clamp = r;
      end
      if (chain[NUM_STAGES].special) begin
         r_clamp = chain[NUM_STAGES].half ? acctilt_pkg::HALF_TURN : '0;
      end
      angle = r_clamp[acctilt_pkg::OUT_W-1:0];
   end

endmodule

// ===== hdl/accel_tilt_angles.sv =====
// Top level of the accelerometer tilt-angle block: three CORDIC lanes and output stage.
`timescale 1ns / 1ps
//
// Usage
//   Request channel (req_*): one raw sample per request, three signed 16-bit
//   axis counts. A request is taken on a rising edge with req_tvalid and
//   req_tready both high.
//   Response channel (rsp_*): one response per request, in request order,
//   carrying roll = atan2(y,z), pitch = atan2(x,z) and heading = atan2(x,y),
//   each signed, 1/128 degree, clamped to +/-180 degrees.
//   Three lanes run side by side, each a vectoring CORDIC with one register
//   per micro-rotation; the output register merges the three angles.
//   Throughput: one request per cycle, sustained while rsp_tready keeps up.
//   Pipeline: from acceptance to rsp_tvalid a sample passes the fold
//   register, one register per micro-rotation and the output register;
//   the stage count of the CORDIC chain sets its depth.
//   Stall: while a response waits, the pipeline keeps moving until the last
//   stage holds a finished sample; only then does req_tready drop.
//   Reset (synchronous, active high) empties the pipeline and the output
//   register; no request is in flight afterwards.
//
module accel_tilt_angles #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // roll[15:0], pitch[31:16], heading[47:32]
);

   localparam int NUM_STAGES = (CORDIC_STAGES < acctilt_pkg::TABLE_SIZE) ?
                               CORDIC_STAGES : acctilt_pkg::TABLE_SIZE;
   localparam int DEPTH      = NUM_STAGES + 1;
   localparam int W          = acctilt_pkg::AXIS_W;

   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [47:0]      rsp_data_ff;
   logic [47:0]      rsp_data_in;
   logic             out_free;
   logic             advance;

   logic signed [W-1:0] accel_x;
   logic signed [W-1:0] accel_y;
   logic signed [W-1:0] accel_z;
   logic signed [W-1:0] lane_num   [3];
   logic signed [W-1:0] lane_den   [3];
   logic signed [acctilt_pkg::OUT_W-1:0] lane_angle [3];

   assign accel_x = req_tdata[W-1:0];
   assign accel_y = req_tdata[2*W-1:W];
   assign accel_z = req_tdata[3*W-1:2*W];

   // roll, pitch, heading
   assign lane_num[0] = accel_y;
   assign lane_den[0] = accel_z;
   assign lane_num[1] = accel_x;
   assign lane_den[1] = accel_z;
   assign lane_num[2] = accel_x;
   assign lane_den[2] = accel_y;

   // The output register is free when empty or being drained this cycle.
   // Hold the whole pipeline only when its last stage is full and cannot move.
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign advance  = out_free || !valid_ff[DEPTH-1];

   for (genvar l = 0; l < 3; l++) begin : g_lane
      acctilt_lane #(
         .NUM_STAGES (NUM_STAGES)
      ) u_lane (
         .clock  (clock),
         .enable (advance),
         .num    (lane_num[l]),
         .den    (lane_den[l]),
         .angle  (lane_angle[l])
      );
   end

   // Advance the valid marks alongside the lane payload.
   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = {valid_ff[DEPTH-2:0], req_tvalid};
      end
   end

   // Merge the three lane angles into one response; hold it while stalled.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = valid_ff[DEPTH-1];
         rsp_data_in  = {lane_angle[2], lane_angle[1], lane_angle[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hdl/acctilt_checker.sv =====
// Port-level checker for the tilt-angle block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module acctilt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   logic signed [15:0] roll;
   logic signed [15:0] pitch;
   logic signed [15:0] heading;
   logic               in_range;

   assign roll     = rsp_tdata[15:0];
   assign pitch    = rsp_tdata[31:16];
   assign heading  = rsp_tdata[47:32];
   assign in_range = (roll    <= 16'sd23040) && (roll    >= -16'sd23040) &&
                     (pitch   <= 16'sd23040) && (pitch   >= -16'sd23040) &&
                     (heading <= 16'sd23040) && (heading >= -16'sd23040);

   // a stalled response keeps its data
   `ACT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata))
   // no response straight out of reset
   `ACT_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)
   // every angle lies within a half turn
   `ACT_ASSERT_NOW(a_angle_range, clock, reset, rsp_tvalid, in_range)
   // with the output empty, requests are never refused
   `ACT_ASSERT_NOW(a_ready_when_empty, clock, reset, req_tvalid && !rsp_tvalid,
                   req_tready)

endmodule

bind accel_tilt_angles acctilt_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== test/accel_tilt_angles_tb.sv =====
// Self-checking testbench for the accelerometer tilt-angle block: directed corners and random stream traffic.
`timescale 1ns / 1ps

module accel_tilt_angles_tb;

   localparam int CORDIC_STAGES = 16;
   localparam int STEP_COUNT    = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
   localparam int PIPE_LATENCY  = STEP_COUNT + 2;
   localparam int RANDOM_ITEMS  = 2000;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_CYCLES   = 200;

   localparam int      ANGLE_SHIFT   = 24;
   localparam int      ROUND_SHIFT   = 17;
   localparam longint  RIGHT_ANGLE   = 64'sd1509949440;   // 90 degrees, 2^-24 units
   localparam longint  STRAIGHT_LSB  = 64'sd23040;        // 180 degrees, 1/128 units

   // atan(2^-i) in degrees scaled by 2^24
   localparam longint ARCTAN_STEPS [24] = '{
      754974720, 445687602, 235489088, 119537938,
      60000934,  30029717,  15018523,  7509720,
      3754917,   1877466,   938734,    469367,
      234684,    117342,    58671,     29335,
      14668,     7334,      3667,      1833,
      917,       458,       229,       115
   };

   typedef struct packed {
      logic signed [15:0] heading;
      logic signed [15:0] pitch;
      logic signed [15:0] roll;
   } tilt_angles_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // roll[15:0], pitch[31:16], heading[47:32]

   logic [47:0]  pending_samples [$];
   tilt_angles_t expected_angles [$];

   int error_count = 0;
   int cycle_count = 0;

   // sender burst state
   int burst_left = 1;
   int gap_left   = 0;

   // receiver stall state
   int          responses_taken = 0;
   int          hold_left       = 0;
   int          next_hold_at    = 300;
   int          pattern_phase   = 0;
   logic [31:0] ready_pattern   = '1;

   accel_tilt_angles #(
      .CORDIC_STAGES(CORDIC_STAGES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Vectoring CORDIC on raw counts: angle of (den, num) in 1/128 degree.
   function automatic logic signed [15:0] tilt_angle(input longint num, input longint den);
      longint vx, vy, acc, sx, sy, rounded;
      if (num == 0)
         return (den < 0) ? 16'(STRAIGHT_LSB) : 16'sd0;
      // fold a left half-plane vector by a quarter turn
      if (den < 0) begin
         if (num > 0) begin
            vx = num;  vy = -den; acc = RIGHT_ANGLE;
         end else begin
            vx = -num; vy = den;  acc = -RIGHT_ANGLE;
         end
      end else begin
         vx = den; vy = num; acc = 0;
      end
      vx = vx * (longint'(1) << ANGLE_SHIFT);
      vy = vy * (longint'(1) << ANGLE_SHIFT);
      for (int i = 0; i < STEP_COUNT; i++) begin
         sx = vx >>> i;
         sy = vy >>> i;
         if (vy >= 0) begin
            vx = vx + sy; vy = vy - sx; acc = acc + ARCTAN_STEPS[i];
         end else begin
            vx = vx - sy; vy = vy + sx; acc = acc - ARCTAN_STEPS[i];
         end
      end
      // round half up, then clamp to a half turn either way
      rounded = (acc + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      if (rounded > STRAIGHT_LSB)
         rounded = STRAIGHT_LSB;
      if (rounded < -STRAIGHT_LSB)
         rounded = -STRAIGHT_LSB;
      return 16'(rounded);
   endfunction

   function automatic tilt_angles_t angles_of_sample(input logic [47:0] sample);
      tilt_angles_t a;
      longint ax, ay, az;
      ax = longint'($signed(sample[15:0]));
      ay = longint'($signed(sample[31:16]));
      az = longint'($signed(sample[47:32]));
      a.roll    = tilt_angle(ay, az);
      a.pitch   = tilt_angle(ax, az);
      a.heading = tilt_angle(ax, ay);
      return a;
   endfunction

   // Skew axis values towards zero, the axes and the extremes.
   function automatic logic [15:0] random_axis();
      logic [15:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: v = 16'($urandom());
         5, 6:          v = 16'(int'($urandom_range(0, 8)) - 4);
         7: begin
            case ($urandom_range(0, 5))
               0:       v = 16'h8000;
               1:       v = 16'h7FFF;
               2:       v = 16'h8001;
               3:       v = 16'hFFFF;
               4:       v = 16'h0001;
               default: v = 16'h0000;
            endcase
         end
         8:       v = 16'h0000;
         default: v = 16'(int'($urandom_range(0, 600)) - 300);
      endcase
      return v;
   endfunction

   function automatic logic [47:0] axis_sample(input int x, input int y, input int z);
      return {16'(z), 16'(y), 16'(x)};
   endfunction

   // Sender: offer pending samples in bursts, hold each one until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready)
            expected_angles.push_back(angles_of_sample(req_tdata));
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_samples.pop_front();
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 48);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall on a rolling pattern, with a long hold-off now and then
   // so that the pipeline fills and the request side backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            responses_taken++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (responses_taken >= next_hold_at) begin
            hold_left    = HOLD_CYCLES - 1;
            next_hold_at = next_hold_at + 700;
            rsp_tready <= 1'b0;
         end else begin
            if (pattern_phase == 0) begin
               case ($urandom_range(0, 3))
                  0:       ready_pattern = '1;
                  1:       ready_pattern = $urandom();
                  2:       ready_pattern = $urandom() & $urandom();
                  default: ready_pattern = $urandom() | $urandom();
               endcase
            end
            rsp_tready <= ready_pattern[pattern_phase];
            pattern_phase = (pattern_phase + 1) % 32;
         end
      end
   end

   // Compare each response with the oldest outstanding prediction.
   always @(posedge clock) begin : check_responses
      tilt_angles_t want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = tilt_angles_t'(rsp_tdata);
         if (expected_angles.size() == 0) begin
            if (error_count < 10)
               $display("%0t: unexpected response roll=%0d pitch=%0d heading=%0d",
                        $realtime, got.roll, got.pitch, got.heading);
            error_count++;
         end else begin
            want = expected_angles.pop_front();
            if (got.roll !== want.roll || got.pitch !== want.pitch ||
                got.heading !== want.heading) begin
               if (error_count < 10)
                  $display("%0t: mismatch exp roll=%0d pitch=%0d heading=%0d, got %0d %0d %0d",
                           $realtime, want.roll, want.pitch, want.heading,
                           got.roll, got.pitch, got.heading);
               error_count++;
            end
         end
      end
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      // directed corners: zeros, extremes, zero numerators, left half-plane, near +/-180
      pending_samples.push_back(axis_sample(0, 0, 0));
      pending_samples.push_back(axis_sample(32767, 32767, 32767));
      pending_samples.push_back(axis_sample(-32768, -32768, -32768));
      pending_samples.push_back(axis_sample(32767, -32768, 32767));
      pending_samples.push_back(axis_sample(-32768, 32767, -32768));
      pending_samples.push_back(axis_sample(0, 0, -5));
      pending_samples.push_back(axis_sample(0, 7, -1));
      pending_samples.push_back(axis_sample(0, -32768, 12));
      pending_samples.push_back(axis_sample(0, 0, 32767));
      pending_samples.push_back(axis_sample(1000, 0, 0));
      pending_samples.push_back(axis_sample(-1000, -3, 0));
      pending_samples.push_back(axis_sample(100, -100, -100));
      pending_samples.push_back(axis_sample(-100, 100, -100));
      pending_samples.push_back(axis_sample(1, 1, -32768));
      pending_samples.push_back(axis_sample(-1, -1, -32768));
      pending_samples.push_back(axis_sample(1, -32768, -32768));
      pending_samples.push_back(axis_sample(-1, -32768, 1));
      pending_samples.push_back(axis_sample(32767, 1, 1));
      pending_samples.push_back(axis_sample(-32768, -1, 32767));
      pending_samples.push_back(axis_sample(1, -1, -1));
      pending_samples.push_back(axis_sample(-1, 1, 1));
      for (int n = 0; n < RANDOM_ITEMS; n++)
         pending_samples.push_back({random_axis(), random_axis(), random_axis()});

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // drain: every request taken, every response back, then a tail for strays
      do
         @(negedge clock);
      while (pending_samples.size() != 0 || req_tvalid || expected_angles.size() != 0);
      repeat (PIPE_LATENCY * 2) @(negedge clock);

      if (error_count == 0 && expected_angles.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== accel_tilt_angles.f =====
+incdir+hdl
hdl/acctilt_pkg.sv
hdl/acctilt_stage.sv
hdl/acctilt_lane.sv
hdl/accel_tilt_angles.sv
hdl/acctilt_checker.sv
test/accel_tilt_angles_tb.sv
